### src/assert_macros.svh
// Assertion macros shared by the banked priority deque RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define ASSERT_IMPLIES_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_IMPLIES_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### src/bpd_pkg.sv
// Types and fixed field widths of the banked priority deque.
package bpd_pkg;

	localparam int QIDX_FIELD_W = 5;
	localparam int LEN_FIELD_W  = 4;

	localparam logic FUNC_ADD  = 1'b0;
	localparam logic FUNC_TAKE = 1'b1;

	typedef enum logic [1:0] {
		OUT_ADDED = 2'd0,
		OUT_FULL  = 2'd1,
		OUT_TAKEN = 2'd2,
		OUT_EMPTY = 2'd3
	} outcome_t;

endpackage

### src/bpd_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
module bpd_ram #(
	parameter int DEPTH  = 32,
	parameter int WIDTH  = 8,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data only changes when a read is issued, so it holds through stalls.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/banked_priority_deque.sv
// Top level of the banked priority deque: a bank of bounded ring-buffer queues.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+--------------------------------------------
//  s_      | in        | s_tvalid, s_tready | tuser: func; tdata: queue_index, entry_id,
//          |           |                    |        urgent
//  m_      | out       | m_tvalid, m_tready | tuser: outcome; tdata: taken_id,
//          |           |                    |        taken_urgent, length_after
//
// Sustained rate is one transfer per cycle while m_tready stays high; each result passes
// through the stage-one registers and then the output register before its output transfer.
// The rate is set by the per-queue metadata RAM (head pointer and count): it is read when
// an item is taken in and written back when that item leaves stage one, with the new value
// forwarded when the next item addresses the same queue.
// Reset clears every count at once through one valid flop per queue; there is no clearing
// pass, and the entry RAM is never cleared because only live slots are read.
// A low m_tready holds a valid output register and the middle stage; s_tready then drops
// once the middle stage is occupied and cannot move on.
module banked_priority_deque
	import bpd_pkg::*;
#(
	parameter int NUM_QUEUES  = 32,
	parameter int QUEUE_DEPTH = 8,
	parameter int ID_WIDTH    = 16,
	localparam int IN_DATA_W  = ((QIDX_FIELD_W + ID_WIDTH + 1 + 7) / 8) * 8,
	localparam int OUT_DATA_W = ((ID_WIDTH + 1 + LEN_FIELD_W + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // queue_index, entry_id, urgent, zero pad
	input  logic [0:0]            s_tuser,   // func

	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // taken_id, taken_urgent, length_after, zero pad
	output logic [1:0]            m_tuser    // outcome
);

	`include "assert_macros.svh"

	// Derived widths. The queue index is widened by one bit so that the bank size itself
	// fits in the range compare.
	localparam int QIDX_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int QX_W    = ((QIDX_W > QIDX_FIELD_W) ? QIDX_W : QIDX_FIELD_W) + 1;
	localparam int HP_W    = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int META_W  = CNT_W + HP_W;
	localparam int SUM_W   = ((HP_W > CNT_W) ? HP_W : CNT_W) + 1;
	localparam int ENT_N   = NUM_QUEUES * QUEUE_DEPTH;
	localparam int EA_W    = (ENT_N > 1) ? $clog2(ENT_N) : 1;
	localparam int ENT_W   = ID_WIDTH + 1;

	// Input field extraction.
	logic                    in_func;
	logic [QIDX_FIELD_W-1:0] in_qidx;
	logic [ID_WIDTH-1:0]     in_id;
	logic                    in_urgent;
	logic [QX_W-1:0]         in_qext;
	logic                    in_range;
	logic [QIDX_W-1:0]       in_idx;

	assign in_func   = s_tuser[0];
	assign in_qidx   = s_tdata[QIDX_FIELD_W-1:0];
	assign in_id     = s_tdata[QIDX_FIELD_W +: ID_WIDTH];
	assign in_urgent = s_tdata[QIDX_FIELD_W + ID_WIDTH];
	assign in_qext   = QX_W'(in_qidx);
	assign in_range  = in_qext < QX_W'(NUM_QUEUES);
	// An out-of-bank index is parked on queue zero; its read result is ignored.
	assign in_idx    = in_range ? in_qext[QIDX_W-1:0] : '0;

	// Handshake and stage movement.
	logic valid_s1;
	logic out_valid_s2;
	logic adv2;
	logic go;
	logic s_acc;

	assign adv2     = !out_valid_s2 || m_tready;
	assign go       = valid_s1 && adv2;
	assign s_tready = !valid_s1 || adv2;
	assign s_acc    = s_tvalid && s_tready;

	// Stage one registers: the item itself while its metadata is read.
	logic                func_s1;
	logic [QIDX_W-1:0]   idx_s1;
	logic [ID_WIDTH-1:0] id_s1;
	logic                urgent_s1;
	logic                range_s1;
	logic                mvalid_s1;
	logic                fwd_s1;
	logic [META_W-1:0]   fwd_meta_s1;

	// Per-queue metadata valid bits; a queue whose bit is clear reads as empty.
	logic [NUM_QUEUES-1:0] mvalid_q;

	// Metadata RAM signals.
	logic              meta_we;
	logic [META_W-1:0] meta_wdata;
	logic [META_W-1:0] meta_rdata;

	// Entry RAM signals.
	logic             ent_we;
	logic             ent_re;
	logic [EA_W-1:0]  ent_addr;
	logic [ENT_W-1:0] ent_wdata;
	logic [ENT_W-1:0] ent_rdata;

	// Stage one decode.
	logic [META_W-1:0] meta_cur;
	logic [CNT_W-1:0]  cnt_cur;
	logic [HP_W-1:0]   head_cur;
	logic [SUM_W-1:0]  tail_sum;
	logic [HP_W-1:0]   tail_slot;
	logic [HP_W-1:0]   head_dec;
	logic [HP_W-1:0]   head_inc;
	logic [HP_W-1:0]   slot;
	logic [HP_W-1:0]   head_new;
	logic [CNT_W-1:0]  cnt_new;
	outcome_t          outcome_s1;
	logic              fwd_hit;

	// The forwarded value covers the write that lands on the same edge as the read.
	assign meta_cur = fwd_s1 ? fwd_meta_s1 : (mvalid_s1 ? meta_rdata : '0);
	assign cnt_cur  = meta_cur[HP_W +: CNT_W];
	assign head_cur = meta_cur[HP_W-1:0];

	// Tail slot is head plus count, wrapped once around the ring.
	assign tail_sum  = SUM_W'(head_cur) + SUM_W'(cnt_cur);
	assign tail_slot = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
		HP_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : HP_W'(tail_sum);
	assign head_dec  = (head_cur == '0) ? HP_W'(QUEUE_DEPTH - 1) : head_cur - HP_W'(1);
	assign head_inc  = (head_cur == HP_W'(QUEUE_DEPTH - 1)) ? '0 : head_cur + HP_W'(1);

	always_comb begin
		outcome_s1 = OUT_EMPTY;
		meta_we    = 1'b0;
		ent_we     = 1'b0;
		ent_re     = 1'b0;
		slot       = head_cur;
		head_new   = head_cur;
		cnt_new    = cnt_cur;
		if (!range_s1) begin
			// A queue outside the bank answers full on add and empty on take.
			outcome_s1 = (func_s1 == FUNC_ADD) ? OUT_FULL : OUT_EMPTY;
			cnt_new    = '0;
		end else if (func_s1 == FUNC_ADD) begin
			if (cnt_cur == CNT_W'(QUEUE_DEPTH)) begin
				outcome_s1 = OUT_FULL;
			end else begin
				outcome_s1 = OUT_ADDED;
				meta_we    = go;
				ent_we     = go;
				cnt_new    = cnt_cur + CNT_W'(1);
				if (urgent_s1) begin
					// An urgent entry moves the head back one slot and lands there.
					slot     = head_dec;
					head_new = head_dec;
				end else begin
					slot = tail_slot;
				end
			end
		end else begin
			if (cnt_cur == '0) begin
				outcome_s1 = OUT_EMPTY;
			end else begin
				outcome_s1 = OUT_TAKEN;
				meta_we    = go;
				ent_re     = go;
				slot       = head_cur;
				head_new   = head_inc;
				cnt_new    = cnt_cur - CNT_W'(1);
			end
		end
	end

	assign meta_wdata = {cnt_new, head_new};
	assign ent_addr   = EA_W'(idx_s1) * EA_W'(QUEUE_DEPTH) + EA_W'(slot);
	assign ent_wdata  = {urgent_s1, id_s1};
	assign fwd_hit    = meta_we && in_range && (in_idx == idx_s1);

	bpd_ram #(
		.DEPTH (NUM_QUEUES),
		.WIDTH (META_W),
		.ADDR_W(QIDX_W)
	) u_meta_ram (
		.clk  (clk),
		.we   (meta_we),
		.waddr(idx_s1),
		.wdata(meta_wdata),
		.re   (s_acc),
		.raddr(in_idx),
		.rdata(meta_rdata)
	);

	bpd_ram #(
		.DEPTH (ENT_N),
		.WIDTH (ENT_W),
		.ADDR_W(EA_W)
	) u_entry_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_addr),
		.wdata(ent_wdata),
		.re   (ent_re),
		.raddr(ent_addr),
		.rdata(ent_rdata)
	);

	// Control state: stage valids and the per-queue valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_s2 <= 1'b0;
			fwd_s1       <= 1'b0;
			mvalid_q     <= '0;
		end else begin
			if (s_acc) begin
				valid_s1 <= 1'b1;
				fwd_s1   <= fwd_hit;
			end else if (go) begin
				valid_s1 <= 1'b0;
				fwd_s1   <= 1'b0;
			end
			if (go) begin
				out_valid_s2 <= 1'b1;
			end else if (m_tready) begin
				out_valid_s2 <= 1'b0;
			end
			if (meta_we) begin
				mvalid_q[idx_s1] <= 1'b1;
			end
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			func_s1     <= in_func;
			idx_s1      <= in_idx;
			id_s1       <= in_id;
			urgent_s1   <= in_urgent;
			range_s1    <= in_range;
			mvalid_s1   <= mvalid_q[in_idx];
			fwd_meta_s1 <= meta_wdata;
		end
	end

	// Output register. The taken entry arrives from the entry RAM read register.
	outcome_t               outcome_s2;
	logic [LEN_FIELD_W-1:0] len_s2;

	always_ff @(posedge clk) begin
		if (go) begin
			outcome_s2 <= outcome_s1;
			len_s2     <= LEN_FIELD_W'(cnt_new);
		end
	end

	logic                is_taken;
	logic [ID_WIDTH-1:0] out_id;
	logic                out_urgent;

	assign is_taken   = (outcome_s2 == OUT_TAKEN);
	assign out_id     = is_taken ? ent_rdata[ID_WIDTH-1:0] : '0;
	assign out_urgent = is_taken ? ent_rdata[ID_WIDTH] : 1'b0;

	assign m_tvalid = out_valid_s2;
	assign m_tuser  = outcome_s2;
	assign m_tdata  = OUT_DATA_W'({len_s2, out_urgent, out_id});

	// A take only reads a slot of a queue that holds at least one entry.
	`ASSERT_IMPLIES(a_take_nonempty, clk, arst_n, ent_re, cnt_cur != '0)
	// A written count never exceeds the queue depth.
	`ASSERT_IMPLIES(a_count_bound, clk, arst_n, meta_we, cnt_new <= CNT_W'(QUEUE_DEPTH))
	// A new item only enters stage one when the previous one moves on.
	`ASSERT_IMPLIES(a_accept_moves, clk, arst_n, s_acc && valid_s1, go)
	// Rejected or empty items leave the entry RAM untouched.
	`ASSERT_IMPLIES(a_no_stray_write, clk, arst_n, go && !meta_we, !ent_we && !ent_re)
	// A stage that moves on presents a valid result in the next cycle.
	`ASSERT_IMPLIES_NEXT(a_go_output, clk, arst_n, go, out_valid_s2)

endmodule
